// ===== hw/rtl/lzbd_pkg.sv =====
// Shared types and constants for the LZ back-reference decompressor.
// Holds the word structs of both channels; no dependencies.
`default_nettype none

package lzbd_pkg;

  // History depth used unless the top level is given another one.
  localparam int unsigned HISTORY_DEPTH_DEF = 4096;

  // The written-byte count stops here, well beyond the largest distance.
  localparam logic [12:0] WRITTEN_MAX = 13'd8191;

  // Bias added to the length and distance fields of a back-reference.
  localparam logic [5:0]  LEN_BIAS  = 6'd2;
  localparam logic [11:0] DIST_BIAS = 12'd4;

  typedef struct packed {
    logic       start_req;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       before_origin;
    logic       stream_done;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lzbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined until written.
`default_nettype none

module lzbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // The read data holds while no read is issued.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lz_backref_decompressor_core.sv =====
// LZ back-reference decompressor: header, literal runs and history copies.
// Depends on lzbd_pkg and lzbd_ram (history ring of HISTORY_DEPTH bytes).
// Header, token and literal words are taken one per cycle (literal words only
// while the output is free); a literal byte is registered on the output in the
// cycle after it is taken. A back-reference holds the input: a history read,
// then one byte per cycle from the registered read while the output is free.
// Synchronous reset clears the parser; the history is not cleared.
`default_nettype none

module lz_backref_decompressor_core #(
  parameter int unsigned HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           comp_valid,
  output logic                comp_ready,
  input  wire lzbd_pkg::in_t  comp_data,
  output logic                plain_valid,
  input  wire logic           plain_ready,
  output lzbd_pkg::out_t      plain_data
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_TOKEN   = 6'b000010,
    PH_LITERAL = 6'b000100,
    PH_BACKREF = 6'b001000,
    PH_COPY    = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  phase_t        phase, phase_next;
  logic [1:0]    hdr_idx, hdr_idx_next;
  logic [31:0]   tok_total, tok_total_next;
  logic [31:0]   tok_done, tok_done_next;
  logic [6:0]    lit_left, lit_left_next;
  logic [7:0]    held, held_next;
  logic [AW-1:0] wp, wp_next;
  logic [12:0]   wr_cnt, wr_cnt_next;
  logic [5:0]    copy_left, copy_left_next;
  logic [11:0]   ref_dist, ref_dist_next;

  logic          slot_free, accept;
  phase_t        eff_phase;
  logic [1:0]    eff_idx;
  logic [31:0]   eff_total, hdr_total;
  logic [31:0]   tok_done_inc;
  logic          tok_final;
  logic [AW-1:0] wp_inc;
  logic [11:0]   ref_dist_new;
  logic [7:0]    b;

  logic          emit, emit_last, emit_before, emit_done;
  logic [7:0]    emit_byte;

  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Address of the byte that lies d places behind position p on the ring.
  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] p, input logic [11:0] d);
    logic [AW:0] de;
    logic [AW:0] s;
    de = {{(AW - 11){1'b0}}, d};
    if ({1'b0, p} >= de) begin
      s = {1'b0, p} - de;
    end else begin
      s = {1'b0, p} + DEPTH_W - de;
    end
    return s[AW-1:0];
  endfunction

  assign b          = comp_data.data_byte;
  assign slot_free  = !plain_valid || plain_ready;
  assign comp_ready = (phase != PH_COPY) && ((phase != PH_LITERAL) || slot_free);
  assign accept     = comp_valid && comp_ready;

  // A start word restarts the parser before the word itself is parsed.
  assign eff_phase = comp_data.start_req ? PH_HEADER : phase;
  assign eff_idx   = comp_data.start_req ? 2'd0 : hdr_idx;
  assign eff_total = comp_data.start_req ? 32'd0 : tok_total;
  assign hdr_total = eff_total | ({24'd0, b} << {eff_idx, 3'b000});

  assign tok_done_inc = tok_done + 32'd1;
  assign tok_final    = (tok_done_inc == tok_total);
  assign wp_inc       = (wp == WP_LAST) ? '0 : wp + 1'b1;
  assign ref_dist_new = {1'b0, held[2:0], b} + lzbd_pkg::DIST_BIAS;

  always_comb begin
    phase_next     = phase;
    hdr_idx_next   = hdr_idx;
    tok_total_next = tok_total;
    tok_done_next  = tok_done;
    lit_left_next  = lit_left;
    held_next      = held;
    wp_next        = wp;
    wr_cnt_next    = wr_cnt;
    copy_left_next = copy_left;
    ref_dist_next  = ref_dist;
    emit           = 1'b0;
    emit_byte      = b;
    emit_last      = 1'b1;
    emit_before    = 1'b0;
    emit_done      = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = ring_back(wp_inc, ref_dist);

    if (accept) begin
      if (comp_data.start_req) begin
        tok_done_next = '0;
        lit_left_next = '0;
        held_next     = '0;
        wp_next       = '0;
        wr_cnt_next   = '0;
      end
      case (eff_phase)
        PH_HEADER: begin
          tok_total_next = hdr_total;
          hdr_idx_next   = eff_idx + 2'd1;
          phase_next     = PH_HEADER;
          if (eff_idx == 2'd3) begin
            tok_done_next = '0;
            phase_next    = (hdr_total == 32'd0) ? PH_DONE : PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          if (b[7]) begin
            lit_left_next = b[6:0];
            if (b[6:0] == 7'd0) begin
              // An empty run still counts as a token.
              tok_done_next = tok_done_inc;
              phase_next    = tok_final ? PH_DONE : PH_TOKEN;
            end else begin
              phase_next = PH_LITERAL;
            end
          end else begin
            held_next  = b;
            phase_next = PH_BACKREF;
          end
        end
        PH_LITERAL: begin
          emit          = 1'b1;
          lit_left_next = lit_left - 7'd1;
          if (lit_left == 7'd1) begin
            tok_done_next = tok_done_inc;
            emit_done     = tok_final;
            phase_next    = tok_final ? PH_DONE : PH_TOKEN;
          end
        end
        PH_BACKREF: begin
          copy_left_next = {1'b0, held[7:3]} + lzbd_pkg::LEN_BIAS;
          ref_dist_next  = ref_dist_new;
          ram_re         = 1'b1;
          ram_raddr      = ring_back(wp, ref_dist_new);
          phase_next     = PH_COPY;
        end
        default: begin
        end
      endcase
    end else if ((phase == PH_COPY) && slot_free) begin
      // The RAM output holds the source of the current copy step.
      emit        = 1'b1;
      emit_before = ({1'b0, ref_dist} > wr_cnt);
      emit_byte   = emit_before ? 8'd0 : ram_rdata;
      if (copy_left == 6'd1) begin
        tok_done_next = tok_done_inc;
        emit_done     = tok_final;
        phase_next    = tok_final ? PH_DONE : PH_TOKEN;
      end else begin
        emit_last      = 1'b0;
        copy_left_next = copy_left - 6'd1;
        ram_re         = 1'b1;
      end
    end

    if (emit) begin
      wp_next     = wp_inc;
      wr_cnt_next = (wr_cnt == lzbd_pkg::WRITTEN_MAX) ? wr_cnt : wr_cnt + 13'd1;
    end
  end

  // Every distance is at least four, so the next read never meets this write.
  lzbd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (emit),
    .waddr (wp),
    .wdata (emit_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      hdr_idx     <= '0;
      tok_total   <= '0;
      tok_done    <= '0;
      lit_left    <= '0;
      wp          <= '0;
      wr_cnt      <= '0;
      copy_left   <= '0;
      plain_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      hdr_idx   <= hdr_idx_next;
      tok_total <= tok_total_next;
      tok_done  <= tok_done_next;
      lit_left  <= lit_left_next;
      wp        <= wp_next;
      wr_cnt    <= wr_cnt_next;
      copy_left <= copy_left_next;
      if (emit) begin
        plain_valid <= 1'b1;
      end else if (plain_ready) begin
        plain_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held     <= held_next;
    ref_dist <= ref_dist_next;
    if (emit) begin
      plain_data.out_byte      <= emit_byte;
      plain_data.run_last      <= emit_last;
      plain_data.before_origin <= emit_before;
      plain_data.stream_done   <= emit_done;
    end
  end

  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (emit && ram_re) |-> (wp != ram_raddr))
    else $error("history read and write hit the same entry");

  a_copy_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_COPY) |-> ((copy_left != 6'd0) && (copy_left <= 6'd33)))
    else $error("copy length out of range");

  a_copy_ends: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_COPY) && emit && (copy_left == 6'd1)) |=> (phase != PH_COPY))
    else $error("copy did not end after its last byte");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (plain_valid && plain_data.stream_done) |-> plain_data.run_last)
    else $error("stream end on a word that is not the last of its run");

  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    (plain_valid && plain_data.before_origin) |-> (plain_data.out_byte == 8'd0))
    else $error("copy from before the origin gave a nonzero byte");

endmodule

`default_nettype wire
